// File: hw/rtl/ipv4v_pkg.sv
// ----------------------------------------------------------------------------
// ipv4v_pkg
// Shared types, status codes and helper functions for the IPv4 dotted-quad
// validator.
// ----------------------------------------------------------------------------
package ipv4v_pkg;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiNine = 8'h39;
  localparam logic [7:0] AsciiDot  = 8'h2E;
  localparam logic [9:0] SegMax    = 10'd255;

  localparam logic [1:0] MaxDigits = 2'd3;
  localparam logic [1:0] MaxDots   = 2'd3;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StDigits   = 3'd1,
    StDot      = 3'd2,
    StRange    = 3'd3,
    StBadChar  = 3'd4,
    StDotCount = 3'd5
  } status_e;

  // One character beat as it travels from the input stage to the parser.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_string;
  } beat_t;

  // Result handed from the parser to the output stage.
  typedef struct packed {
    logic    valid;
    status_e status;
  } result_t;

  // True when the segment held in the digit registers exceeds 255.
  function automatic logic seg_over(input logic [1:0]       count,
                                    input logic [2:0][3:0]  dig);
    logic [9:0] d0;
    logic [9:0] d1;
    logic [9:0] d2;
    logic [9:0] val;
    d0 = {6'd0, dig[0]};
    d1 = {6'd0, dig[1]};
    d2 = {6'd0, dig[2]};
    unique case (count)
      2'd1:    val = d0;
      2'd2:    val = 10'(d0 * 10'd10) + d1;
      2'd3:    val = 10'(d0 * 10'd100) + 10'(d1 * 10'd10) + d2;
      default: val = 10'd0;
    endcase
    return val > SegMax;
  endfunction

endpackage

// File: hw/rtl/ipv4v_in_stage.sv
// ----------------------------------------------------------------------------
// ipv4v_in_stage
// Input register for character beats.
// ----------------------------------------------------------------------------
module ipv4v_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ipv4v_pkg::beat_t beat_i,
  input  logic            advance_i,
  output logic            valid_o,
  output ipv4v_pkg::beat_t beat_o
);

  logic             valid_q, valid_d;
  ipv4v_pkg::beat_t beat_q;

  // The register can take a new beat when empty or when its beat moves on.
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// File: hw/rtl/ipv4v_parser.sv
// ----------------------------------------------------------------------------
// ipv4v_parser
// Per-string parse state and the combinational per-beat character update.
// ----------------------------------------------------------------------------
module ipv4v_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  ipv4v_pkg::beat_t   beat_i,
  output ipv4v_pkg::result_t result_o
);

  logic [1:0]         dcnt_q, dcnt_d;
  logic [2:0][3:0]    dig_q, dig_d;
  logic [1:0]         dots_q, dots_d;
  logic               err_q, err_d;
  ipv4v_pkg::status_e code_q, code_d;

  logic is_digit;
  logic is_dot;
  logic last;

  assign is_digit = (beat_i.char_byte >= ipv4v_pkg::AsciiZero) &&
                    (beat_i.char_byte <= ipv4v_pkg::AsciiNine);
  assign is_dot   = (beat_i.char_byte == ipv4v_pkg::AsciiDot);
  assign last     = beat_i.end_of_string;

  always_comb begin
    dcnt_d = dcnt_q;
    dig_d  = dig_q;
    dots_d = dots_q;
    err_d  = err_q;
    code_d = code_q;
    if (!err_q) begin
      if (is_digit) begin
        if (dcnt_q == ipv4v_pkg::MaxDigits) begin
          err_d  = 1'b1;
          code_d = ipv4v_pkg::StDigits;
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (dcnt_q == 2'(i)) begin
              dig_d[i] = beat_i.char_byte[3:0];
            end
          end
          dcnt_d = dcnt_q + 2'd1;
        end
      end else if (is_dot) begin
        if (last || (dots_q == ipv4v_pkg::MaxDots)) begin
          err_d  = 1'b1;
          code_d = ipv4v_pkg::StDot;
        end else if (ipv4v_pkg::seg_over(dcnt_q, dig_q)) begin
          err_d  = 1'b1;
          code_d = ipv4v_pkg::StRange;
        end else begin
          dcnt_d = 2'd0;
          dots_d = dots_q + 2'd1;
        end
      end else begin
        err_d  = 1'b1;
        code_d = ipv4v_pkg::StBadChar;
      end
    end
  end

  // Final status is judged on the state after this beat has been applied.
  always_comb begin
    result_o.valid = fire_i && last;
    if (err_d) begin
      result_o.status = code_d;
    end else if (ipv4v_pkg::seg_over(dcnt_d, dig_d)) begin
      result_o.status = ipv4v_pkg::StRange;
    end else if (dots_d != ipv4v_pkg::MaxDots) begin
      result_o.status = ipv4v_pkg::StDotCount;
    end else begin
      result_o.status = ipv4v_pkg::StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= 2'd0;
      dig_q  <= '0;
      dots_q <= 2'd0;
      err_q  <= 1'b0;
      code_q <= ipv4v_pkg::StOk;
    end else if (fire_i) begin
      if (last) begin
        dcnt_q <= 2'd0;
        dig_q  <= '0;
        dots_q <= 2'd0;
        err_q  <= 1'b0;
        code_q <= ipv4v_pkg::StOk;
      end else begin
        dcnt_q <= dcnt_d;
        dig_q  <= dig_d;
        dots_q <= dots_d;
        err_q  <= err_d;
        code_q <= code_d;
      end
    end
  end

endmodule

// File: hw/rtl/ipv4v_out_stage.sv
// ----------------------------------------------------------------------------
// ipv4v_out_stage
// Result register holding one status beat until it is taken.
// ----------------------------------------------------------------------------
module ipv4v_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ipv4v_pkg::result_t result_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         parse_status_o
);

  logic               valid_q, valid_d;
  ipv4v_pkg::status_e status_q;

  // Free when empty or when the held beat leaves at this edge.
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (result_i.valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      status_q <= result_i.status;
    end
  end

  assign out_valid_o    = valid_q;
  assign parse_status_o = status_q;

endmodule

// File: hw/rtl/ipv4_dotted_quad_validator_unit.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_validator_unit
// Checks a character stream as a dotted-decimal IPv4 address.
// ----------------------------------------------------------------------------
// Flow: a final character accepted into the input register has its status beat
// written into the result register when that register is free; while an untaken
// status beat still holds the result register, it waits for that beat to leave.
// Throughput: one character beat per cycle unless a final beat waits on an untaken
// status beat, set by the combinational parse update between the two registers.
// Reset: rst_ni clears both stage valid flags and the parse state at once.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_validator_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] parse_status_o
);

  ipv4v_pkg::beat_t   in_beat;
  ipv4v_pkg::beat_t   s1_beat;
  ipv4v_pkg::result_t result;
  logic               s1_valid;
  logic               s1_advance;
  logic               out_free;
  logic               fire;

  assign in_beat.char_byte     = char_byte_i;
  assign in_beat.end_of_string = end_of_string_i;

  // A staged beat that produces no result never waits. A final beat waits
  // only while the result register still holds a status nobody has taken.
  assign s1_advance = !s1_beat.end_of_string || out_free;
  assign fire       = s1_valid && s1_advance;

  ipv4v_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .beat_i     (in_beat),
    .advance_i  (s1_advance),
    .valid_o    (s1_valid),
    .beat_o     (s1_beat)
  );

  // The parser owns the per-string state; it applies one beat per fire and
  // returns to its reset state after the final beat of a string.
  ipv4v_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .beat_i   (s1_beat),
    .result_o (result)
  );

  ipv4v_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .result_i       (result),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .parse_status_o (parse_status_o)
  );

endmodule

// File: hw/rtl/ipv4v_checker.sv
// ----------------------------------------------------------------------------
// ipv4v_checker
// Port-level assertions for the IPv4 dotted-quad validator.
// ----------------------------------------------------------------------------
module ipv4v_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] char_byte_i,
  input logic       end_of_string_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] parse_status_o
);

  // A waiting status beat stays put with its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(parse_status_o))
    else $error("status beat dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> parse_status_o <= 3'd5)
    else $error("status code out of range");

  // A new status beat must follow an accepted final character.
  a_rise_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && end_of_string_i, 2))
    else $error("status beat without a final character");

  // Input back-pressure only comes from an untaken status beat.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule

bind ipv4_dotted_quad_validator_unit ipv4v_checker u_ipv4v_checker (.*);
